// ----- rtl/ksg_pkg.sv -----
// ksg_pkg: shared types and constants for the keyframe aligned segmenter
// used by the channel interfaces and the top level; no dependencies

package ksg_pkg;

  // segments kept in the sliding window (1 to 255)
  localparam int unsigned WindowSegments = 8;
  localparam int unsigned FillW          = $clog2(WindowSegments + 1);

  localparam int unsigned PtsW   = 64;
  localparam int unsigned GapW   = 36;
  localparam int unsigned SegNumW  = 32;
  localparam int unsigned PartNumW = 16;
  localparam int unsigned SeqW     = 32;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SEGMENT_CUT_GAP = 1'b0,
    CFG_PART_MIN        = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [PtsW-1:0] pts_ns;
    logic            is_keyframe;
  } in_item_t;

  typedef struct packed {
    logic                new_segment;
    logic [SegNumW-1:0]  segment_number;
    logic                new_part;
    logic [PartNumW-1:0] part_number;
    logic                part_independent;
    logic                closed_segment_valid;
    logic [PtsW-1:0]     closed_segment_duration;
    logic                closed_part_valid;
    logic [PtsW-1:0]     closed_part_duration;
    logic [SeqW-1:0]     media_sequence;
  } out_item_t;

endpackage

// ----- rtl/ksg_if.sv -----
// ksg_if: valid/ready channel interfaces for samples, results and register writes
// depends on ksg_pkg for the payload types

interface ksg_in_if
  import ksg_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ksg_out_if
  import ksg_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ksg_cfg_if
  import ksg_pkg::*;
();
  logic            valid;
  logic            ready;
  cfg_index_t      index;
  logic [GapW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/keyframe_aligned_segmenter.sv -----
// keyframe_aligned_segmenter: cuts a stream of video samples into segments and parts
// depends on ksg_pkg and the channel interfaces in ksg_if.sv
//
// Usage:
//   in_ch carries one sample per request (timestamp in ns, keyframe flag). out_ch
//   returns exactly one result per sample, in order: segment/part open flags and
//   numbers, durations of a closed segment and part, and the media sequence number.
//   cfg_ch writes the cut gap (index 0) and the part minimum (index 1); it is always
//   ready and should only be written while no sample is in flight.
// Pipeline and throughput:
//   a sample is taken into the input register, and its result is then loaded into
//   the output register, from which out_ch presents it; while out_ch stalls, the
//   sample waits in the input register. One sample per cycle is sustained while out_ch is ready; the
//   limit is the 64 bit subtract and compare against the segment and part start times.
// Reset:
//   rst_n (synchronous, active low) empties both registers and returns the gaps and
//   all counters to their initial values; the first sample then opens segment 1.
// Stalls:
//   while out_ch is not ready the result holds, the input register still fills, and
//   in_ch drops ready only once both are occupied.

module keyframe_aligned_segmenter
  import ksg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ksg_in_if.sink            in_ch,
  ksg_out_if.source         out_ch,
  ksg_cfg_if.sink           cfg_ch
);

  // configuration registers
  logic [GapW-1:0]     seg_gap_r;
  logic [GapW-1:0]     part_min_r;

  // input register
  logic                s1_valid_r;
  in_item_t            s1_item_r;

  // segmenter state
  logic                have_seg_r,   have_seg_nxt;
  logic [PtsW-1:0]     seg_start_r,  seg_start_nxt;
  logic [PtsW-1:0]     part_start_r, part_start_nxt;
  logic [SegNumW-1:0]  seg_num_r,    seg_num_nxt;
  logic [PartNumW-1:0] part_num_r,   part_num_nxt;
  logic                part_indep_r, part_indep_nxt;
  logic [FillW-1:0]    fill_r,       fill_nxt;
  logic [SeqW-1:0]     mseq_r,       mseq_nxt;

  // output register
  logic                out_valid_r;
  out_item_t           out_item_r,   out_item_nxt;

  logic                advance;
  logic [PtsW-1:0]     seg_dist;
  logic [PtsW-1:0]     part_dist;
  logic                open_seg;
  logic                cut_seg;
  logic                open_part;

  // handshakes
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_gap_r  <= GapW'(64'd2000000000);
      part_min_r <= GapW'(64'd200000000);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_SEGMENT_CUT_GAP: seg_gap_r  <= cfg_ch.data;
        CFG_PART_MIN:        part_min_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_ch.data;
    end
  end

  // segment and part decisions
  always_comb begin
    seg_dist  = s1_item_r.pts_ns - seg_start_r;
    part_dist = s1_item_r.pts_ns - part_start_r;

    cut_seg   = have_seg_r && s1_item_r.is_keyframe &&
                (seg_dist > {{(PtsW-GapW){1'b0}}, seg_gap_r});
    open_seg  = !have_seg_r || cut_seg;
    open_part = open_seg || (part_dist >= {{(PtsW-GapW){1'b0}}, part_min_r});

    have_seg_nxt   = have_seg_r;
    seg_start_nxt  = seg_start_r;
    part_start_nxt = part_start_r;
    seg_num_nxt    = seg_num_r;
    part_num_nxt   = part_num_r;
    part_indep_nxt = part_indep_r;
    fill_nxt       = fill_r;
    mseq_nxt       = mseq_r;

    if (open_seg) begin
      have_seg_nxt  = 1'b1;
      seg_start_nxt = s1_item_r.pts_ns;
      seg_num_nxt   = seg_num_r + SegNumW'(1);
      if (fill_r < FillW'(WindowSegments)) begin
        fill_nxt = fill_r + FillW'(1);
      end else begin
        mseq_nxt = mseq_r + SeqW'(1);
      end
    end

    if (open_part) begin
      part_start_nxt = s1_item_r.pts_ns;
      part_indep_nxt = s1_item_r.is_keyframe;
      part_num_nxt   = open_seg ? '0 : part_num_r + PartNumW'(1);
    end

    out_item_nxt.new_segment             = open_seg;
    out_item_nxt.segment_number          = seg_num_nxt;
    out_item_nxt.new_part                = open_part;
    out_item_nxt.part_number             = part_num_nxt;
    out_item_nxt.part_independent        = part_indep_nxt;
    out_item_nxt.closed_segment_valid    = cut_seg;
    out_item_nxt.closed_segment_duration = cut_seg ? seg_dist : '0;
    out_item_nxt.closed_part_valid       = have_seg_r && open_part;
    out_item_nxt.closed_part_duration    = (have_seg_r && open_part) ? part_dist : '0;
    out_item_nxt.media_sequence          = mseq_nxt;
  end

  // state update on each sample that moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_seg_r   <= 1'b0;
      seg_start_r  <= '0;
      part_start_r <= '0;
      seg_num_r    <= '0;
      part_num_r   <= '1;
      part_indep_r <= 1'b0;
      fill_r       <= '0;
      mseq_r       <= SeqW'(1);
    end else if (advance) begin
      have_seg_r   <= have_seg_nxt;
      seg_start_r  <= seg_start_nxt;
      part_start_r <= part_start_nxt;
      seg_num_r    <= seg_num_nxt;
      part_num_r   <= part_num_nxt;
      part_indep_r <= part_indep_nxt;
      fill_r       <= fill_nxt;
      mseq_r       <= mseq_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

// ----- bench/testbench.sv -----
// testbench: randomized and directed check of keyframe_aligned_segmenter
// depends on ksg_pkg, the channel interfaces in ksg_if.sv and the top level

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ksg_pkg::*;

  localparam bit [GapW-1:0] GapMax        = '1;
  localparam int unsigned   SettleCycles  = 8;
  localparam int unsigned   LongHold      = 60;
  localparam int unsigned   QuietLimit    = 2000;
  localparam int unsigned   MaxPrinted    = 40;

  // tracks segmenter state and the cut decisions still owed by the block
  class segment_scoreboard;
    bit [GapW-1:0]     cut_gap;
    bit [GapW-1:0]     part_min;
    bit                have_segment;
    bit [PtsW-1:0]     seg_start;
    bit [PtsW-1:0]     part_start;
    bit [SegNumW-1:0]  next_seg_num;
    bit [SegNumW-1:0]  cur_seg_num;
    bit [PartNumW-1:0] next_part_num;
    bit                cur_part_indep;
    int unsigned       window_fill;
    bit [SeqW-1:0]     media_seq;
    out_item_t         awaited_cuts[$];
    int unsigned       errors;
    int unsigned       samples;
    int unsigned       cuts_seen;
    int unsigned       segments_opened;
    int unsigned       parts_opened;

    function new();
      cut_gap        = GapW'(64'd2000000000);
      part_min       = GapW'(64'd200000000);
      have_segment   = 1'b0;
      seg_start      = '0;
      part_start     = '0;
      next_seg_num   = 1;
      cur_seg_num    = 0;
      next_part_num  = 0;
      cur_part_indep = 1'b0;
      window_fill    = 0;
      media_seq      = 1;
    endfunction

    function void set_register(cfg_index_t idx, bit [GapW-1:0] value);
      case (idx)
        CFG_SEGMENT_CUT_GAP: cut_gap = value;
        CFG_PART_MIN:        part_min = value;
        default:             ;
      endcase
    endfunction

    // work out the cut decision for one accepted sample
    function void note_sample(in_item_t s);
      out_item_t     e;
      bit [PtsW-1:0] since_seg;
      bit [PtsW-1:0] since_part;
      bit [PtsW-1:0] gap_wide;
      bit [PtsW-1:0] min_wide;
      bit            open_seg;
      bit            open_part;
      e          = '0;
      gap_wide   = cut_gap;
      min_wide   = part_min;
      since_seg  = s.pts_ns - seg_start;
      since_part = s.pts_ns - part_start;
      open_seg   = !have_segment || (since_seg > gap_wide && s.is_keyframe);
      open_part  = 1'b0;
      samples++;
      // a segment change also closes the last part of the old segment
      if (have_segment && open_seg) begin
        e.closed_segment_valid    = 1'b1;
        e.closed_segment_duration = since_seg;
        e.closed_part_valid       = 1'b1;
        e.closed_part_duration    = since_part;
      end
      if (open_seg) begin
        have_segment  = 1'b1;
        seg_start     = s.pts_ns;
        cur_seg_num   = next_seg_num;
        next_seg_num  = next_seg_num + 1'b1;
        next_part_num = '0;
        // full window slides the media sequence forward
        if (window_fill < WindowSegments) window_fill++;
        else media_seq = media_seq + 1'b1;
        open_part = 1'b1;
        segments_opened++;
      end else if (since_part >= min_wide) begin
        open_part              = 1'b1;
        e.closed_part_valid    = 1'b1;
        e.closed_part_duration = since_part;
      end
      if (open_part) begin
        part_start     = s.pts_ns;
        next_part_num  = next_part_num + 1'b1;
        cur_part_indep = s.is_keyframe;
        parts_opened++;
      end
      e.new_segment      = open_seg;
      e.segment_number   = cur_seg_num;
      e.new_part         = open_part;
      e.part_number      = next_part_num - 1'b1;
      e.part_independent = cur_part_indep;
      e.media_sequence   = media_seq;
      awaited_cuts.insert(awaited_cuts.size(), e);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (errors < MaxPrinted)
        $display("mismatch at result %0d: %s got %0h expected %0h", cuts_seen, what, got,
                 want);
      errors++;
    endtask

    // compare one delivered result against the oldest owed decision
    task check_cut(out_item_t got);
      out_item_t want;
      cuts_seen++;
      if (awaited_cuts.size() == 0) begin
        report_mismatch("result with no sample outstanding", '0, '0);
        return;
      end
      want = awaited_cuts[0];
      awaited_cuts.delete(0);
      if (got.new_segment !== want.new_segment)
        report_mismatch("new_segment", got.new_segment, want.new_segment);
      if (got.segment_number !== want.segment_number)
        report_mismatch("segment_number", got.segment_number, want.segment_number);
      if (got.new_part !== want.new_part)
        report_mismatch("new_part", got.new_part, want.new_part);
      if (got.part_number !== want.part_number)
        report_mismatch("part_number", got.part_number, want.part_number);
      if (got.part_independent !== want.part_independent)
        report_mismatch("part_independent", got.part_independent, want.part_independent);
      if (got.closed_segment_valid !== want.closed_segment_valid)
        report_mismatch("closed_segment_valid", got.closed_segment_valid,
                        want.closed_segment_valid);
      if (got.closed_segment_duration !== want.closed_segment_duration)
        report_mismatch("closed_segment_duration", got.closed_segment_duration,
                        want.closed_segment_duration);
      if (got.closed_part_valid !== want.closed_part_valid)
        report_mismatch("closed_part_valid", got.closed_part_valid, want.closed_part_valid);
      if (got.closed_part_duration !== want.closed_part_duration)
        report_mismatch("closed_part_duration", got.closed_part_duration,
                        want.closed_part_duration);
      if (got.media_sequence !== want.media_sequence)
        report_mismatch("media_sequence", got.media_sequence, want.media_sequence);
    endtask
  endclass

  logic clk;
  logic rst_n;

  ksg_in_if  in_ch();
  ksg_out_if out_ch();
  ksg_cfg_if cfg_ch();

  segment_scoreboard sb = new();

  bit            calm;
  bit            long_hold_req;
  bit [PtsW-1:0] last_pts;
  int unsigned   reg_writes;
  int unsigned   quiet_cycles;

  keyframe_aligned_segmenter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // offer one sample and wait for it to be taken, with an occasional gap after
  task automatic send_sample(bit [PtsW-1:0] pts, bit key);
    in_item_t s;
    s.pts_ns      = pts;
    s.is_keyframe = key;
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s);
    last_pts = pts;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_register(cfg_index_t idx, bit [GapW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_register(idx, value);
    reg_writes++;
  endtask

  // wait for the block to drain, then load both thresholds
  task automatic apply_settings(bit [GapW-1:0] gap, bit [GapW-1:0] pmin);
    in_ch.valid <= 1'b0;
    while (sb.awaited_cuts.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    write_register(CFG_SEGMENT_CUT_GAP, gap);
    write_register(CFG_PART_MIN, pmin);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly rising timestamps, some landing right on the thresholds, some noise
  task automatic random_run(int unsigned count, bit [PtsW-1:0] step_max,
                            int unsigned key_odds, bit with_hold);
    bit [PtsW-1:0] pts;
    bit            key;
    int unsigned   pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 31);
      key  = ($urandom_range(0, key_odds - 1) == 0);
      if (pick == 0) pts = {$urandom, $urandom};
      else if (pick == 1) pts = last_pts - $urandom_range(0, 1000);
      else if (pick < 5) pts = sb.seg_start + sb.cut_gap + $urandom_range(0, 1);
      else if (pick < 8) pts = sb.part_start + sb.part_min - $urandom_range(0, 1);
      else pts = last_pts + ({$urandom, $urandom} % (step_max + 1'b1));
      if (with_hold && i == count / 2) long_hold_req = 1'b1;
      send_sample(pts, key);
    end
  endtask

  // result receiver: random stalls plus one long hold-off on request
  initial begin
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_cut(out_ch.data);
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no request moved for %0d cycles", QuietLimit);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_SEGMENT_CUT_GAP;
    cfg_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: first sample, boundaries, backwards and wrapping timestamps
    send_sample(64'd0, 1'b0);
    send_sample(64'd100000000, 1'b0);
    send_sample(64'd199999999, 1'b1);
    send_sample(64'd200000000, 1'b1);
    send_sample(64'd2000000000, 1'b1);
    send_sample(64'd2000000001, 1'b0);
    send_sample(64'd2000000001, 1'b1);
    send_sample(64'd5, 1'b1);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_sample(64'd10, 1'b1);
    send_sample(64'h8000_0000_0000_0000, 1'b1);
    random_run(130, 64'd70000000, 4, 1'b0);

    // zero thresholds: equal timestamps, a segment per keyframe, window filling up
    apply_settings('0, '0);
    send_sample(last_pts, 1'b1);
    repeat (10) send_sample(last_pts + 1'b1, 1'b1);
    send_sample(last_pts + 1'b1, 1'b0);
    random_run(120, 64'd3, 2, 1'b0);

    // full scale thresholds
    apply_settings(GapMax, GapMax);
    random_run(100, 64'hFFFF_FFFF, 4, 1'b0);

    // short thresholds with the receiver holding off long enough to fill the block
    apply_settings(GapW'(1000), GapW'(300));
    random_run(150, 64'd150, 6, 1'b1);

    apply_settings('0, GapMax);
    random_run(80, 64'd1000, 3, 1'b0);

    // closing stretch at streaming rate with no idling
    calm = 1'b1;
    apply_settings(GapW'(64'd2000000000), GapW'(64'd200000000));
    random_run(150, 64'd70000000, 4, 1'b0);

    in_ch.valid <= 1'b0;
    while (sb.awaited_cuts.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d samples: %0d segments and %0d parts opened, %0d register writes",
             sb.samples, sb.segments_opened, sb.parts_opened, reg_writes);
    $display("thresholds ran at zero, full scale and in between, with one long hold-off");
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ksg_pkg.sv
rtl/ksg_if.sv
rtl/keyframe_aligned_segmenter.sv
bench/testbench.sv
